FILE: hdl/cie_pkg.sv
package cie_pkg;

   localparam logic [7:0] OP_STOP    = 8'h10;
   localparam logic [7:0] OP_SCF     = 8'h37;
   localparam logic [7:0] OP_CCF     = 8'h3F;
   localparam logic [7:0] OP_DI      = 8'hF3;
   localparam logic [7:0] OP_EI      = 8'hFB;
   localparam logic [7:0] OP_ADD_D8  = 8'hC6;
   localparam logic [7:0] OP_OR_D8   = 8'hF6;
   localparam logic [7:0] OP_ADD_SP  = 8'hE8;
   localparam logic [7:0] OP_JP      = 8'hC3;
   localparam logic [7:0] OP_JP_HL   = 8'hE9;

   localparam logic [1:0] PAIR_HL = 2'd2;
   localparam logic [1:0] PAIR_SP = 2'd3;
   localparam logic [2:0] SEL_HLB = 3'd6;
   localparam logic [2:0] SEL_A   = 3'd7;

   typedef struct packed {
      logic [7:0] opcode;
      logic [7:0] imm_low;
      logic [7:0] imm_high;
      logic [7:0] hl_byte;
      logic [7:0] stack_low;
      logic [7:0] stack_high;
   } req_type;

   typedef struct packed {
      logic        write_valid;
      logic [15:0] write_addr;
      logic [7:0]  write_data;
      logic        last;
      logic [15:0] next_pc;
      logic [15:0] next_sp;
      logic [15:0] next_hl;
      logic [7:0]  accum;
      logic [3:0]  flag_nibble;
      logic        int_enable;
   } rsp_type;

   // architectural state kept in flops
   typedef struct packed {
      logic [7:0]  a;
      logic [3:0]  f;
      logic [15:0] sp;
      logic [15:0] pc;
      logic        ime;
   } arch_type;

   typedef struct packed {
      arch_type    nxt;
      logic [15:0] hl;
      logic        wr_en;
      logic [1:0]  wr_addr;
      logic [15:0] wr_data;
      logic [1:0]  nwr;
      logic [15:0] waddr0;
      logic [7:0]  wdata0;
      logic [15:0] waddr1;
      logic [7:0]  wdata1;
   } exec_type;

   // ALU-group opcodes select their source by the low bits, all others by bits 5:4
   function automatic logic [1:0] rd_addr(input logic [7:0] op);
      return (op[7:6] == 2'b10) ? op[2:1] : op[5:4];
   endfunction

endpackage

FILE: hdl/cie_regfile.sv
module cie_regfile (
   input  logic        clock,
   input  logic        reset,
   input  logic        rd_en,
   input  logic [1:0]  rd_addr,
   output logic [15:0] rd_data,
   output logic [15:0] hl_data,
   input  logic        wr_en,
   input  logic [1:0]  wr_addr,
   input  logic [15:0] wr_data
);
   import cie_pkg::*;

   logic [15:0] mem [4];
   logic [3:0]  valid_ff;
   logic [15:0] rd_data_ff;
   logic [15:0] hl_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // write-first: a read that meets the same-edge write takes the new data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && wr_addr == rd_addr) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : 16'h0000;
         end
         if (wr_en && wr_addr == PAIR_HL) begin
            hl_data_ff <= wr_data;
         end else begin
            hl_data_ff <= valid_ff[PAIR_HL] ? mem[PAIR_HL] : 16'h0000;
         end
      end
   end

   assign rd_data = rd_data_ff;
   assign hl_data = hl_data_ff;

endmodule

FILE: hdl/cie_exec.sv
module cie_exec (
   input  cie_pkg::req_type  item,
   input  logic [15:0]       rd0,
   input  logic [15:0]       hl,
   input  cie_pkg::arch_type cur,
   output cie_pkg::exec_type ex
);
   import cie_pkg::*;

   logic [7:0]  op;
   logic [2:0]  r;
   logic [1:0]  p;
   logic [15:0] pv;
   logic [15:0] imm16;
   logic [7:0]  v;
   logic [7:0]  b;
   logic [8:0]  s9;
   logic [4:0]  s5;
   logic [16:0] s17;
   logic [12:0] s13;
   logic [15:0] ext;
   logic        fl;
   logic [15:0] ret;

   function automatic logic [7:0] r_get(input logic [2:0] sel, input logic [15:0] pair,
                                        input logic [7:0] hlb, input logic [7:0] a);
      logic [7:0] res;
      if (sel == SEL_HLB) res = hlb;
      else if (sel == SEL_A) res = a;
      else res = sel[0] ? pair[7:0] : pair[15:8];
      return res;
   endfunction

   always_comb begin
      op    = item.opcode;
      r     = op[5:3];
      p     = op[5:4];
      pv    = (p == PAIR_SP) ? cur.sp : rd0;
      imm16 = {item.imm_high, item.imm_low};
      v     = '0;
      b     = '0;
      s9    = '0;
      s5    = '0;
      s17   = '0;
      s13   = '0;
      ext   = '0;
      fl    = 1'b0;
      ret   = cur.pc + 16'd1;

      ex         = '0;
      ex.nxt     = cur;
      ex.nxt.pc  = cur.pc + 16'd1;

      if (op == OP_STOP) begin
         ex.nxt.pc = cur.pc + 16'd2;
      end else if (op == OP_SCF) begin
         ex.nxt.f = {cur.f[3], 3'b001};
      end else if (op == OP_CCF) begin
         ex.nxt.f = {cur.f[3], 2'b00, ~cur.f[0]};
      end else if (op == OP_DI) begin
         ex.nxt.ime = 1'b0;
      end else if (op == OP_EI) begin
         ex.nxt.ime = 1'b1;
      end else if ((op & 8'hC6) == 8'h04) begin
         // INC/DEC r, (HL)
         v = r_get(r, rd0, item.hl_byte, cur.a);
         if (op[0]) begin
            v = v - 8'd1;
            ex.nxt.f = {v == 8'h00, 1'b1, v[3:0] == 4'hF, cur.f[0]};
         end else begin
            v = v + 8'd1;
            ex.nxt.f = {v == 8'h00, 1'b0, v[3:0] == 4'h0, cur.f[0]};
         end
         if (r == SEL_HLB) begin
            ex.waddr0 = hl;
            ex.wdata0 = v;
            ex.nwr    = 2'd1;
         end else if (r == SEL_A) begin
            ex.nxt.a = v;
         end else begin
            ex.wr_en   = 1'b1;
            ex.wr_addr = r[2:1];
            ex.wr_data = r[0] ? {rd0[15:8], v} : {v, rd0[7:0]};
         end
      end else if ((op & 8'hCF) == 8'h03 || (op & 8'hCF) == 8'h0B) begin
         s17[15:0] = op[3] ? pv - 16'd1 : pv + 16'd1;
         if (p == PAIR_SP) begin
            ex.nxt.sp = s17[15:0];
         end else begin
            ex.wr_en   = 1'b1;
            ex.wr_addr = p;
            ex.wr_data = s17[15:0];
         end
      end else if ((op & 8'hCF) == 8'h09) begin
         s17 = {1'b0, hl} + {1'b0, pv};
         s13 = {1'b0, hl[11:0]} + {1'b0, pv[11:0]};
         ex.nxt.f   = {cur.f[3], 1'b0, s13[12], s17[16]};
         ex.wr_en   = 1'b1;
         ex.wr_addr = PAIR_HL;
         ex.wr_data = s17[15:0];
      end else if ((op & 8'hF8) == 8'h80 || op == OP_ADD_D8) begin
         b  = (op == OP_ADD_D8) ? item.imm_low : r_get(op[2:0], rd0, item.hl_byte, cur.a);
         s9 = {1'b0, cur.a} + {1'b0, b};
         s5 = {1'b0, cur.a[3:0]} + {1'b0, b[3:0]};
         ex.nxt.a = s9[7:0];
         ex.nxt.f = {s9[7:0] == 8'h00, 1'b0, s5[4], s9[8]};
         if (op == OP_ADD_D8) ex.nxt.pc = cur.pc + 16'd2;
      end else if ((op & 8'hF8) == 8'hB0 || op == OP_OR_D8) begin
         b = (op == OP_OR_D8) ? item.imm_low : r_get(op[2:0], rd0, item.hl_byte, cur.a);
         ex.nxt.a = cur.a | b;
         ex.nxt.f = {(cur.a | b) == 8'h00, 3'b000};
         if (op == OP_OR_D8) ex.nxt.pc = cur.pc + 16'd2;
      end else if (op == OP_ADD_SP) begin
         ext = {{8{item.imm_low[7]}}, item.imm_low};
         s9  = {1'b0, cur.sp[7:0]} + {1'b0, item.imm_low};
         s5  = {1'b0, cur.sp[3:0]} + {1'b0, item.imm_low[3:0]};
         ex.nxt.f  = {2'b00, s5[4], s9[8]};
         ex.nxt.sp = cur.sp + ext;
         ex.nxt.pc = cur.pc + 16'd2;
      end else if ((op & 8'hCF) == 8'hC5) begin
         ex.waddr0 = cur.sp - 16'd1;
         ex.waddr1 = cur.sp - 16'd2;
         if (p == PAIR_SP) begin
            ex.wdata0 = cur.a;
            ex.wdata1 = {cur.f, 4'b0000};
         end else begin
            ex.wdata0 = rd0[15:8];
            ex.wdata1 = rd0[7:0];
         end
         ex.nwr    = 2'd2;
         ex.nxt.sp = cur.sp - 16'd2;
      end else if ((op & 8'hCF) == 8'hC1) begin
         if (p == PAIR_SP) begin
            ex.nxt.a = item.stack_high;
            ex.nxt.f = item.stack_low[7:4];
         end else begin
            ex.wr_en   = 1'b1;
            ex.wr_addr = p;
            ex.wr_data = {item.stack_high, item.stack_low};
         end
         ex.nxt.sp = cur.sp + 16'd2;
      end else if (op == OP_JP) begin
         ex.nxt.pc = imm16;
      end else if (op == OP_JP_HL) begin
         ex.nxt.pc = hl;
      end else if ((op & 8'hE7) == 8'hC2) begin
         fl = op[4] ? cur.f[0] : cur.f[3];
         ex.nxt.pc = ((op[3] ? fl : !fl)) ? imm16 : cur.pc + 16'd3;
      end else if ((op & 8'hC7) == 8'hC7) begin
         ex.waddr0 = cur.sp - 16'd1;
         ex.wdata0 = ret[15:8];
         ex.waddr1 = cur.sp - 16'd2;
         ex.wdata1 = ret[7:0];
         ex.nwr    = 2'd2;
         ex.nxt.sp = cur.sp - 16'd2;
         ex.nxt.pc = {10'b0, op[5:3], 3'b000};
      end

      ex.hl = (ex.wr_en && ex.wr_addr == PAIR_HL) ? ex.wr_data : hl;
   end

endmodule

FILE: hdl/cpu_instruction_executor_subset.sv
// channel   ports                            dir  item
// request   req_valid req_stall req_data      in   opcode, operands, memory bytes
// response  rsp_valid rsp_stall rsp_data      out  memory write or status, last mark
//
// An item is read out of the pair file on the edge it is accepted and executes
// in the next cycle; PUSH and RST take two response slots, every other item takes one.
// A new item is taken at the edge the previous one hands off its last response.
// Synchronous reset clears the state and control registers and the pair file valid bits.
// rsp_stall holds the response register, and through it the execute stage and request side.
module cpu_instruction_executor_subset (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cie_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cie_pkg::rsp_type rsp_data
);
   import cie_pkg::*;

   arch_type    arch_ff;
   logic        e_valid_ff;
   req_type     e_item_ff;
   logic        k_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   logic [15:0] rd0;
   logic [15:0] hl;
   exec_type    ex;
   logic        out_free;
   logic        e_last;
   logic        e_done;
   logic        accept;
   rsp_type     rsp_in;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign e_last    = (ex.nwr != 2'd2) || k_ff;
   assign e_done    = e_valid_ff && out_free && e_last;
   assign req_stall = e_valid_ff && !e_done;
   assign accept    = req_valid && !req_stall;

   cie_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (rd_addr(req_data.opcode)),
      .rd_data (rd0),
      .hl_data (hl),
      .wr_en   (e_done && ex.wr_en),
      .wr_addr (ex.wr_addr),
      .wr_data (ex.wr_data)
   );

   cie_exec u_exec (
      .item (e_item_ff),
      .rd0  (rd0),
      .hl   (hl),
      .cur  (arch_ff),
      .ex   (ex)
   );

   always_comb begin
      rsp_in.write_valid = ex.nwr != 2'd0;
      rsp_in.write_addr  = k_ff ? ex.waddr1 : ex.waddr0;
      rsp_in.write_data  = k_ff ? ex.wdata1 : ex.wdata0;
      rsp_in.last        = e_last;
      rsp_in.next_pc     = ex.nxt.pc;
      rsp_in.next_sp     = ex.nxt.sp;
      rsp_in.next_hl     = ex.hl;
      rsp_in.accum       = ex.nxt.a;
      rsp_in.flag_nibble = ex.nxt.f;
      rsp_in.int_enable  = ex.nxt.ime;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arch_ff      <= '0;
         e_valid_ff   <= 1'b0;
         k_ff         <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (e_valid_ff && out_free) begin
            rsp_valid_ff <= 1'b1;
            k_ff         <= !e_last;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (e_done) begin
            arch_ff <= ex.nxt;
         end
         if (accept) begin
            e_valid_ff <= 1'b1;
         end else if (e_done) begin
            e_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         e_item_ff <= req_data;
      end
      if (e_valid_ff && out_free) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
